[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/mvc_pkg.sv]
package mvc_pkg;

    localparam int MAX_TRIANGLES = 4096;
    localparam int COORD_BITS    = 12;

    localparam int CW      = 12;                       // coordinate port width
    localparam int LIMIT_W = 20;                       // zero volume limit
    localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
    localparam int SUM_W   = CW + 2;                   // a + b + c per axis
    localparam int K_W     = 2 * CW + 1;               // cross product term
    localparam int T_W     = 3 * CW + 2;               // triple product
    localparam int MA_W    = T_W;                      // multiplier operand a
    localparam int MB_W    = SUM_W;                    // multiplier operand b
    localparam int P_W     = MA_W + MB_W;              // multiplier product
    localparam int VOL_W   = 49;
    localparam int WSUM_W  = 62;
    localparam int Q_W     = 13;                       // quotient magnitude bits
    localparam int QS_W    = Q_W + 1;
    localparam int DEN_W   = VOL_W + 2;                // |4 * volume|
    localparam int DSH_W   = DEN_W + Q_W - 1;
    localparam int DIFF_W  = DSH_W + 1;
    localparam int BIT_W   = $clog2(Q_W);
    localparam int STEP_W  = 4;
    localparam int LAST_STEP = 14;
    localparam int SAT_HI  = 2 ** (COORD_BITS - 1) - 1;
    localparam int SAT_MAG = 2 ** (COORD_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRI,
        ST_END,
        ST_DLOAD,
        ST_DSTEP,
        ST_DFIN,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_W_LOAD,
        OP_W_SUB,
        OP_V_LOAD,
        OP_V_SUB,
        OP_T_LOAD,
        OP_T_SUB,
        OP_T_ADD,
        OP_VOL,
        OP_WX,
        OP_WY,
        OP_WZ
    } t_acc_op;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    // Keep the low COORD_BITS bits and sign extend them.
    function automatic logic signed [CW-1:0] coord_of(input logic signed [CW-1:0] raw);
        logic signed [CW-1:0] v;
        v = raw <<< (CW - COORD_BITS);
        return v >>> (CW - COORD_BITS);
    endfunction

endpackage

[hw/rtl/mesh_volume_centroid.sv]
// Volume centroid of a closed triangle mesh piece by signed tetrahedra. Each input word carries
// one triangle (three vertices, signed 12-bit fixed point); a word with end_of_piece set closes
// the piece and yields one output word with the centroid, a degenerate flag (the magnitude of the
// six-times-volume sum is at or below zero_volume_limit, center forced to zero) and an overflow
// flag (triangles beyond MAX_TRIANGLES were dropped). All arithmetic runs on one shared 38x14
// signed multiplier with a registered product, and the division on one shared 64-bit subtract
// and compare. An empty word is taken with no further work; a triangle word is accepted, then
// runs 15 multiplier steps; closing a piece runs a check state, three divisions of 13 quotient
// bits each (load, restoring steps, finish) and emit, or just check and emit if it is degenerate.
// The input stalls for the whole of that time. A finished result waits in an output register,
// so the next word is taken while the previous result is still stalled; a second result waits
// in the emit cycle until the first one leaves. There is no clearing pass after reset.
module mesh_volume_centroid (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mvc_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [mvc_pkg::CW-1:0]      i_a_x,
    input  logic signed [mvc_pkg::CW-1:0]      i_a_y,
    input  logic signed [mvc_pkg::CW-1:0]      i_a_z,
    input  logic signed [mvc_pkg::CW-1:0]      i_b_x,
    input  logic signed [mvc_pkg::CW-1:0]      i_b_y,
    input  logic signed [mvc_pkg::CW-1:0]      i_b_z,
    input  logic signed [mvc_pkg::CW-1:0]      i_c_x,
    input  logic signed [mvc_pkg::CW-1:0]      i_c_y,
    input  logic signed [mvc_pkg::CW-1:0]      i_c_z,
    input  logic                               i_triangle_valid,
    input  logic                               i_end_of_piece,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mvc_pkg::CW-1:0]      o_center_x,
    output logic signed [mvc_pkg::CW-1:0]      o_center_y,
    output logic signed [mvc_pkg::CW-1:0]      o_center_z,
    output logic                               o_degenerate,
    output logic                               o_overflow
);
    import mvc_pkg::*;

    // Sequencer
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    t_axis               r_axis;

    // Latched triangle
    logic signed [CW-1:0]    r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;
    logic signed [SUM_W-1:0] r_sx, r_sy, r_sz;
    logic                    r_end;

    // Triple product datapath
    logic signed [K_W-1:0]   r_w, r_v;
    logic signed [T_W-1:0]   r_t;
    logic signed [P_W-1:0]   r_prod;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_p;
    t_acc_op                 acc_op;

    // Per-piece sums
    logic signed [VOL_W-1:0]  r_vol;
    logic signed [WSUM_W-1:0] r_wx, r_wy, r_wz;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_exceed;
    logic [LIMIT_W-1:0]       r_limit;

    // Divider
    logic [WSUM_W-1:0]        r_rem;
    logic [DSH_W-1:0]         r_dsh;
    logic [Q_W-1:0]           r_q;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_qneg;
    logic signed [CW-1:0]     r_cen_x, r_cen_y, r_cen_z;
    logic                     r_degen;

    // Output register
    logic                     r_o_valid;
    logic signed [CW-1:0]     r_o_cx, r_o_cy, r_o_cz;
    logic                     r_o_degen, r_o_ovf;

    logic                     in_acc;
    logic                     tri_go;
    logic                     emit_go;
    logic [VOL_W-1:0]         vol_mag;
    logic                     degen;
    logic signed [WSUM_W-1:0] num;
    logic [WSUM_W-1:0]        num_mag;
    logic [DEN_W-1:0]         den_mag;
    logic [DIFF_W-1:0]        diff;
    logic                     ge;
    logic signed [QS_W-1:0]   q_res;
    logic signed [CW-1:0]     cen;

    // Handshake and sequencer strobes
    always_comb begin
        o_in_stall = 1'b1;
        emit_go    = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_EMIT: emit_go    = !r_o_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_acc = i_in_valid && !o_in_stall;
    assign tri_go = i_triangle_valid && (r_cnt < CNT_W'(MAX_TRIANGLES));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (tri_go) begin
                        n_state = ST_TRI;
                    end else if (i_end_of_piece) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_TRI: begin
                if (r_step == STEP_W'(LAST_STEP)) begin
                    n_state = r_end ? ST_END : ST_IDLE;
                end
            end
            ST_END:   n_state = degen ? ST_EMIT : ST_DLOAD;
            ST_DLOAD: n_state = ST_DSTEP;
            ST_DSTEP: begin
                if (r_bit == '0) begin
                    n_state = ST_DFIN;
                end
            end
            ST_DFIN:  n_state = (r_axis == AX_Z) ? ST_EMIT : ST_DLOAD;
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Multiplier schedule: a step issues at most one product and may fold in the product of the
    // step before. Cross terms go through w and v, the triple product through t.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        acc_op = OP_NONE;
        case (r_step)
            4'd0: begin mul_a = MA_W'(r_by); mul_b = MB_W'(r_cz); end
            4'd1: begin mul_a = MA_W'(r_bz); mul_b = MB_W'(r_cy); acc_op = OP_W_LOAD; end
            4'd2: begin mul_a = MA_W'(r_bx); mul_b = MB_W'(r_cz); acc_op = OP_W_SUB;  end
            4'd3: begin mul_a = MA_W'(r_bz); mul_b = MB_W'(r_cx); acc_op = OP_V_LOAD; end
            4'd4: begin mul_a = MA_W'(r_w);  mul_b = MB_W'(r_ax); acc_op = OP_V_SUB;  end
            4'd5: begin mul_a = MA_W'(r_v);  mul_b = MB_W'(r_ay); acc_op = OP_T_LOAD; end
            4'd6: begin mul_a = MA_W'(r_bx); mul_b = MB_W'(r_cy); acc_op = OP_T_SUB;  end
            4'd7: begin mul_a = MA_W'(r_by); mul_b = MB_W'(r_cx); acc_op = OP_W_LOAD; end
            4'd8: acc_op = OP_W_SUB;
            4'd9: begin mul_a = MA_W'(r_w);  mul_b = MB_W'(r_az); end
            4'd10: acc_op = OP_T_ADD;
            4'd11: begin mul_a = r_t; mul_b = r_sx; acc_op = OP_VOL; end
            4'd12: begin mul_a = r_t; mul_b = r_sy; acc_op = OP_WX;  end
            4'd13: begin mul_a = r_t; mul_b = r_sz; acc_op = OP_WY;  end
            4'd14: acc_op = OP_WZ;
            default: acc_op = OP_NONE;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Degenerate test and divider operands
    assign vol_mag = r_vol[VOL_W-1] ? $unsigned(-r_vol) : $unsigned(r_vol);
    assign degen   = vol_mag <= VOL_W'(r_limit);
    assign den_mag = {vol_mag, 2'b00};

    always_comb begin
        case (r_axis)
            AX_X:    num = r_wx;
            AX_Y:    num = r_wy;
            default: num = r_wz;
        endcase
    end

    assign num_mag = num[WSUM_W-1] ? $unsigned(-num) : $unsigned(num);
    assign diff    = DIFF_W'(r_rem) - DIFF_W'(r_dsh);
    assign ge      = !diff[DIFF_W-1];

    // Sign and saturate the truncated quotient magnitude
    always_comb begin
        if (r_qneg) begin
            q_res = (r_q >= Q_W'(SAT_MAG)) ? -(QS_W'(SAT_MAG)) : -$signed({1'b0, r_q});
        end else begin
            q_res = (r_q > Q_W'(SAT_HI)) ? QS_W'(SAT_HI) : $signed({1'b0, r_q});
        end
    end

    assign cen = CW'(q_res);

    // Control state and per-piece sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_vol     <= '0;
            r_wx      <= '0;
            r_wy      <= '0;
            r_wz      <= '0;
            r_cnt     <= '0;
            r_exceed  <= 1'b0;
            r_limit   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end

            if (r_state == ST_TRI) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end

            // Drop triangles past the limit, remember that it happened
            if (in_acc && i_triangle_valid && !tri_go) begin
                r_exceed <= 1'b1;
            end

            if (r_state == ST_TRI) begin
                case (acc_op)
                    OP_VOL:  r_vol <= r_vol + VOL_W'(r_t);
                    OP_WX:   r_wx  <= r_wx + WSUM_W'(r_prod);
                    OP_WY:   r_wy  <= r_wy + WSUM_W'(r_prod);
                    OP_WZ:   r_wz  <= r_wz + WSUM_W'(r_prod);
                    default: ;
                endcase
                if (r_step == STEP_W'(LAST_STEP)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            if (emit_go) begin
                r_vol     <= '0;
                r_wx      <= '0;
                r_wy      <= '0;
                r_wz      <= '0;
                r_cnt     <= '0;
                r_exceed  <= 1'b0;
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_end <= i_end_of_piece;
            r_ax  <= coord_of(i_a_x);
            r_ay  <= coord_of(i_a_y);
            r_az  <= coord_of(i_a_z);
            r_bx  <= coord_of(i_b_x);
            r_by  <= coord_of(i_b_y);
            r_bz  <= coord_of(i_b_z);
            r_cx  <= coord_of(i_c_x);
            r_cy  <= coord_of(i_c_y);
            r_cz  <= coord_of(i_c_z);
            r_sx  <= SUM_W'(coord_of(i_a_x)) + SUM_W'(coord_of(i_b_x))
                   + SUM_W'(coord_of(i_c_x));
            r_sy  <= SUM_W'(coord_of(i_a_y)) + SUM_W'(coord_of(i_b_y))
                   + SUM_W'(coord_of(i_c_y));
            r_sz  <= SUM_W'(coord_of(i_a_z)) + SUM_W'(coord_of(i_b_z))
                   + SUM_W'(coord_of(i_c_z));
        end

        if (r_state == ST_TRI) begin
            r_prod <= mul_p;
            case (acc_op)
                OP_W_LOAD: r_w <= K_W'(r_prod);
                OP_W_SUB:  r_w <= r_w - K_W'(r_prod);
                OP_V_LOAD: r_v <= K_W'(r_prod);
                OP_V_SUB:  r_v <= r_v - K_W'(r_prod);
                OP_T_LOAD: r_t <= T_W'(r_prod);
                OP_T_SUB:  r_t <= r_t - T_W'(r_prod);
                OP_T_ADD:  r_t <= r_t + T_W'(r_prod);
                default:   ;
            endcase
        end

        case (r_state)
            ST_END: begin
                r_degen <= degen;
                r_axis  <= AX_X;
                if (degen) begin
                    r_cen_x <= '0;
                    r_cen_y <= '0;
                    r_cen_z <= '0;
                end
            end
            ST_DLOAD: begin
                r_rem  <= num_mag;
                r_dsh  <= {den_mag, {(Q_W-1){1'b0}}};
                r_q    <= '0;
                r_bit  <= BIT_W'(Q_W - 1);
                r_qneg <= num[WSUM_W-1] ^ r_vol[VOL_W-1];
            end
            ST_DSTEP: begin
                // One restoring step: subtract the shifted divisor where it fits
                if (ge) begin
                    r_rem <= WSUM_W'(diff);
                end
                r_q   <= {r_q[Q_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 1'b1;
            end
            ST_DFIN: begin
                case (r_axis)
                    AX_X:    r_cen_x <= cen;
                    AX_Y:    r_cen_y <= cen;
                    default: r_cen_z <= cen;
                endcase
                case (r_axis)
                    AX_X:    r_axis <= AX_Y;
                    default: r_axis <= AX_Z;
                endcase
            end
            default: ;
        endcase

        // Hold the result until the consumer takes it
        if (emit_go) begin
            r_o_cx    <= r_cen_x;
            r_o_cy    <= r_cen_y;
            r_o_cz    <= r_cen_z;
            r_o_degen <= r_degen;
            r_o_ovf   <= r_exceed;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_center_x   = r_o_cx;
    assign o_center_y   = r_o_cy;
    assign o_center_z   = r_o_cz;
    assign o_degenerate = r_o_degen;
    assign o_overflow   = r_o_ovf;

endmodule

[hw/rtl/mvc_checker.sv]
`include "assert_macros.svh"

module mvc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic [mvc_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic signed [mvc_pkg::CW-1:0]      i_a_x,
    input logic signed [mvc_pkg::CW-1:0]      i_a_y,
    input logic signed [mvc_pkg::CW-1:0]      i_a_z,
    input logic signed [mvc_pkg::CW-1:0]      i_b_x,
    input logic signed [mvc_pkg::CW-1:0]      i_b_y,
    input logic signed [mvc_pkg::CW-1:0]      i_b_z,
    input logic signed [mvc_pkg::CW-1:0]      i_c_x,
    input logic signed [mvc_pkg::CW-1:0]      i_c_y,
    input logic signed [mvc_pkg::CW-1:0]      i_c_z,
    input logic                               i_triangle_valid,
    input logic                               i_end_of_piece,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [mvc_pkg::CW-1:0]      o_center_x,
    input logic signed [mvc_pkg::CW-1:0]      o_center_y,
    input logic signed [mvc_pkg::CW-1:0]      o_center_z,
    input logic                               o_degenerate,
    input logic                               o_overflow
);

    logic in_acc;
    logic out_hold;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;

    // Stalled result word stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_center_x) && $stable(o_center_y) && $stable(o_center_z) && $stable(o_degenerate) && $stable(o_overflow))

    // Degenerate piece reports the origin
    `ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_degenerate, o_center_x == '0 && o_center_y == '0 && o_center_z == '0)

    // Empty word leaves the block ready
    `ASSERT_NEXT(a_empty_ready, i_clk, i_rst_n, in_acc && !i_triangle_valid && !i_end_of_piece, !o_in_stall)

    // Closing a piece always keeps the input stalled for the result work
    `ASSERT_NEXT(a_end_busy, i_clk, i_rst_n, in_acc && i_end_of_piece, o_in_stall)

endmodule

bind mesh_volume_centroid mvc_checker u_mvc_checker (.*);
